// ===== rtl/gwm_pkg.sv =====
// Package with shared types, character constants and helpers of the glob wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none
package gwm_pkg;

  localparam int MASK_DEPTH_DEF = 256;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ANY    = 8'h3F;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_CHAR = 2'd1,
    REQ_END  = 2'd2
  } req_type_t;

  typedef struct packed {
    logic       restart;
    logic       step;
    logic       load;
    logic [7:0] position;
    logic [7:0] subj;
  } gwm_ctrl_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gwm_cell.sv =====
// One mask position: stored mask character, active bit and match toward the next cell.
`timescale 1ns / 1ps
`default_nettype none
module gwm_cell #(
  parameter int IDX = 0,
  parameter int LW  = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gwm_pkg::gwm_ctrl_t ctrl,
  input  wire logic [LW-1:0]     len_eff,
  input  wire logic              closed_in,
  input  wire logic              adv_in,
  output logic                   act,
  output logic                   prop,
  output logic                   adv_out
);
  import gwm_pkg::*;

  logic       act_r, act_nxt;
  logic [7:0] mchar_r;
  logic       star_r;
  logic       any_r;
  logic       in_len;
  logic       hit;

  assign in_len  = 32'(len_eff) > 32'(IDX);
  assign hit     = ctrl.load && (32'(ctrl.position) == 32'(IDX));
  assign act     = act_r;
  assign prop    = star_r & in_len;
  assign adv_out = closed_in & in_len & ~star_r & (any_r | (mchar_r == ctrl.subj));

  always_comb begin
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = (IDX == 0);
    end else if (ctrl.step) begin
      act_nxt = adv_in | (closed_in & prop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= (IDX == 0);
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      mchar_r <= fold_upper(ctrl.subj);
      star_r  <= (ctrl.subj == CHAR_STAR);
      any_r   <= (ctrl.subj == CHAR_ANY);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gwm_star_closure.sv =====
// Closure of the active set over star runs, computed as one carry chain.
`timescale 1ns / 1ps
`default_nettype none
module gwm_star_closure #(
  parameter int W = 257
) (
  input  wire logic [W-1:0] act,
  input  wire logic [W-1:0] prop,
  output logic      [W-1:0] closed
);
  import gwm_pkg::*;

  logic [W-1:0] gen;
  logic [W-1:0] sum;

  // The carry into each bit is set when an active star run reaches it.
  assign gen    = act & prop;
  assign sum    = gen + prop;
  assign closed = act | (sum ^ gen ^ prop);

endmodule
`default_nettype wire

// ===== rtl/glob_wildcard_matcher.sv =====
// Top level of the glob wildcard matcher: channels, register port, cell row and result register.
//
// While input is open, the matcher takes one transaction per clock cycle of any kind: a mask load,
// a subject byte or an end of subject. Each mask position is a cell that holds its character and
// an active bit, and a subject byte updates every cell at once, with one carry chain across the row
// closing the active set over runs of stars; that chain is the longest path. The result of an end
// transaction sits in the output register from the next cycle, and input stays open as long as
// that register is empty or is being drained. A mask load, an end transaction or a write of
// mask_length starts a new subject. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module glob_wildcard_matcher #(
  parameter int MASK_DEPTH = gwm_pkg::MASK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_position,
  input  wire logic [7:0]  in_char_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_matched,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gwm_pkg::*;

  localparam int LW = $clog2(MASK_DEPTH + 1);

  logic                  in_fire;
  logic                  cfg_wr;
  logic [7:0]            mask_length_r;
  logic [LW-1:0]         len_eff;
  gwm_ctrl_t             ctrl;
  logic [MASK_DEPTH-1:0] cell_act;
  logic [MASK_DEPTH-1:0] cell_prop;
  logic [MASK_DEPTH-1:0] cell_adv;
  logic [MASK_DEPTH-1:0] chain_in;
  logic [MASK_DEPTH:0]   act_vec;
  logic [MASK_DEPTH:0]   prop_vec;
  logic [MASK_DEPTH:0]   closed;
  logic                  act_end_r, act_end_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_matched_r;
  logic                  end_fire;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata  = paddr[2] ? 32'd0 : {24'd0, mask_length_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_length_r <= 8'd0;
    end else if (cfg_wr) begin
      mask_length_r <= pwdata[7:0];
    end
  end

  assign len_eff = (32'(mask_length_r) > 32'(MASK_DEPTH)) ? LW'(MASK_DEPTH) : LW'(mask_length_r);

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;
  assign end_fire = in_fire && (in_req_type == REQ_END);

  assign ctrl.restart  = cfg_wr | (in_fire && (in_req_type == REQ_LOAD || in_req_type == REQ_END));
  assign ctrl.step     = in_fire && (in_req_type == REQ_CHAR);
  assign ctrl.load     = in_fire && (in_req_type == REQ_LOAD);
  assign ctrl.position = in_position;
  assign ctrl.subj     = (in_req_type == REQ_LOAD) ? in_char_value : fold_upper(in_char_value);

  assign chain_in[0] = 1'b0;

  for (genvar p = 0; p < MASK_DEPTH; p++) begin : g_cell
    if (p > 0) begin : g_link
      assign chain_in[p] = cell_adv[p-1];
    end
    gwm_cell #(
      .IDX(p),
      .LW (LW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .len_eff  (len_eff),
      .closed_in(closed[p]),
      .adv_in   (chain_in[p]),
      .act      (cell_act[p]),
      .prop     (cell_prop[p]),
      .adv_out  (cell_adv[p])
    );
  end

  assign act_vec  = {act_end_r, cell_act};
  assign prop_vec = {1'b0, cell_prop};

  gwm_star_closure #(
    .W(MASK_DEPTH + 1)
  ) u_closure (
    .act   (act_vec),
    .prop  (prop_vec),
    .closed(closed)
  );

  always_comb begin
    act_end_nxt = act_end_r;
    if (ctrl.restart) begin
      act_end_nxt = 1'b0;
    end else if (ctrl.step) begin
      act_end_nxt = cell_adv[MASK_DEPTH-1];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (end_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_end_r   <= act_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      out_matched_r <= closed[len_eff];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  a_restart_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (act_vec == (MASK_DEPTH + 1)'(1)))
    else $error("Active set not restarted after a mask_length write.");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> (out_valid && act_vec == (MASK_DEPTH + 1)'(1)))
    else $error("End transaction did not give a result and restart the subject.");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !end_fire) |=> !out_valid_r)
    else $error("Result appeared without an end transaction.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_matched_r)))
    else $error("Pending result changed while stalled.");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the glob wildcard matcher with stream driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
  import gwm_pkg::*;

  localparam int MDEPTH = MASK_DEPTH_DEF;
  localparam int ITEM_GOAL = 550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_MASK = 40;
  localparam logic [2:0] ADDR_MASK_LENGTH = 3'd0;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] pos;
    logic [7:0] ch;
  } match_req_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_req_type = '0;
  logic [7:0]  in_position = '0;
  logic [7:0]  in_char_value = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire         out_matched;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  glob_wildcard_matcher #(
    .MASK_DEPTH(MDEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_position  (in_position),
    .in_char_value(in_char_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_matched  (out_matched),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  logic [7:0]      mask_mem [MDEPTH];
  logic [MDEPTH:0] active_set;
  logic [7:0]      len_reg;
  bit              expected_matches[$];

  logic [7:0]      plan_mask [MDEPTH];
  int              plan_len = 0;
  match_req_t      req_backlog[$];
  int              gen_count = 0;
  logic [7:0]      border_chars [8] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1, 8'hE1};

  int  cycle_count = 0;
  int  fail_count = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  matches_seen = 0;
  int  stall_cycles = 0;
  int  cfg_writes = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  hold_left = 0;
  int  rx_timer = 0;
  logic [1:0] rx_mode = '0;
  logic [7:0] rx_pattern = 8'hFF;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic void restart_match();
    active_set = '0;
    active_set[0] = 1'b1;
  endfunction

  function automatic void close_stars();
    int p;
    for (p = 0; p < len_reg; p++) begin
      if (active_set[p] && mask_mem[p] == CHAR_STAR) begin
        active_set[p + 1] = 1'b1;
      end
    end
  endfunction

  function automatic void advance_matcher(input match_req_t r);
    logic [MDEPTH:0] nxt;
    logic [7:0] sc;
    int p;
    nxt = '0;
    sc = upcase(r.ch);
    case (r.req)
      REQ_LOAD: begin
        mask_mem[r.pos] = r.ch;
        restart_match();
      end
      REQ_CHAR: begin
        close_stars();
        for (p = 0; p < len_reg; p++) begin
          if (active_set[p]) begin
            if (mask_mem[p] == CHAR_STAR) begin
              nxt[p] = 1'b1;
            end else if (mask_mem[p] == CHAR_ANY || upcase(mask_mem[p]) == sc) begin
              nxt[p + 1] = 1'b1;
            end
          end
        end
        active_set = nxt;
      end
      REQ_END: begin
        close_stars();
        expected_matches.push_back(active_set[len_reg]);
        restart_match();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_req(input logic [1:0] req, input logic [7:0] pos,
                                    input logic [7:0] ch);
    match_req_t r;
    r.req = req;
    r.pos = pos;
    r.ch = ch;
    req_backlog.push_back(r);
    if (req == REQ_LOAD) begin
      plan_mask[pos] = ch;
    end
    if (req != REQ_NONE) begin
      gen_count++;
    end
  endfunction

  function automatic void queue_subject(input byte_q_t s, input bit noisy);
    foreach (s[i]) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        queue_req(REQ_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      queue_req(REQ_CHAR, 8'($urandom_range(0, 255)), s[i]);
    end
    queue_req(REQ_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = ($urandom_range(0, 7) == 0) ? 8'd25 : 8'($urandom_range(0, 5));
    if ($urandom_range(0, 1) == 0) begin
      return CHAR_LOW_A + base;
    end
    return CHAR_LOW_A - CASE_OFFSET + base;
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      return pick_letter();
    end
    if (r < 17) begin
      return 8'($urandom_range(0, 255));
    end
    return border_chars[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] mask_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) begin
      return CHAR_STAR;
    end
    if (r < 8) begin
      return CHAR_ANY;
    end
    if (r < 17) begin
      return pick_letter();
    end
    return text_char();
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if ((c | CASE_OFFSET) >= CHAR_LOW_A && (c | CASE_OFFSET) <= CHAR_LOW_Z &&
        $urandom_range(0, 1) == 1) begin
      return c ^ CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic void derive_subject(output byte_q_t s, input int stretch);
    int p;
    int run;
    s = {};
    for (p = 0; p < plan_len; p++) begin
      if (plan_mask[p] == CHAR_STAR) begin
        run = ($urandom_range(0, stretch) == 0) ? $urandom_range(1, 3) : 0;
        repeat (run) s.push_back(text_char());
      end else if (plan_mask[p] == CHAR_ANY) begin
        s.push_back(text_char());
      end else begin
        s.push_back(mix_case(plan_mask[p]));
      end
    end
  endfunction

  function automatic void mutate_subject(ref byte_q_t s);
    int idx;
    int how;
    how = (s.size() == 0) ? 0 : $urandom_range(0, 2);
    idx = $urandom_range(0, s.size());
    if (how == 0) begin
      s.insert(idx, text_char());
    end else if (how == 1) begin
      s.delete(idx % s.size());
    end else begin
      s[idx % s.size()] = text_char();
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || expected_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mask_length(input logic [7:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MASK_LENGTH;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    len_reg = value;
    restart_match();
    plan_len = int'(value);
    cfg_writes++;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== {24'd0, value}) begin
      $error("mask_length: expected %0d, actual %0d", value, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin : sender
    match_req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0 || req_backlog.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end
      end else begin
        cur = req_backlog.pop_front();
        in_valid <= 1'b1;
        in_req_type <= cur.req;
        in_position <= cur.pos;
        in_char_value <= cur.ch;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) begin
        hold_done <= 1'b1;
      end
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (rx_timer == 0) begin
        rx_mode <= 2'($urandom_range(0, 3));
        rx_timer <= $urandom_range(20, 80);
        rx_pattern <= 8'($urandom);
      end else begin
        rx_timer <= rx_timer - 1;
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
      end
      case (rx_mode)
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= rx_pattern[0];
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    bit exp_m;
    match_req_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_matches.size() == 0) begin
          $error("unexpected transaction on output: matched=%0b", out_matched);
          fail_count++;
        end else begin
          exp_m = expected_matches.pop_front();
          if (out_matched !== exp_m) begin
            $error("matched: expected %0b, actual %0b", exp_m, out_matched);
            fail_count++;
          end
          if (exp_m) begin
            matches_seen++;
          end
        end
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        got.req = in_req_type;
        got.pos = in_position;
        got.ch = in_char_value;
        advance_matcher(got);
      end
      if (in_valid && !in_ready) begin
        stall_cycles++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("glob_wildcard_matcher verification failed");
    $finish;
  end

  initial begin
    byte_q_t subj;
    int p;
    int kind;
    int nsub;
    int stretch;
    int len_pick;
    restart_match();
    len_reg = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty mask, folding, bytes above 127, restarts mid-subject.
    set_mask_length(8'd0);
    subj = {};
    queue_subject(subj, 1'b0);
    subj = {8'h61};
    queue_subject(subj, 1'b0);
    queue_req(REQ_NONE, 8'hFF, 8'hFF);
    set_mask_length(8'd4);
    queue_req(REQ_LOAD, 8'd0, CHAR_LOW_A);
    queue_req(REQ_LOAD, 8'd1, CHAR_STAR);
    queue_req(REQ_LOAD, 8'd2, CHAR_ANY);
    queue_req(REQ_LOAD, 8'd3, 8'hE9);
    subj = {8'h41, 8'h00, 8'hE9};
    queue_subject(subj, 1'b0);
    subj = {8'h61, 8'h71, 8'hC9};
    queue_subject(subj, 1'b0);
    queue_req(REQ_CHAR, 8'd0, 8'h62);
    queue_req(REQ_LOAD, 8'd3, 8'h5A);
    subj = {8'h61, 8'hFF, 8'h6B, 8'h7A};
    queue_subject(subj, 1'b0);
    queue_req(REQ_CHAR, 8'd0, 8'h71);
    set_mask_length(8'd3);
    subj = {8'h41, 8'h62};
    queue_subject(subj, 1'b0);

    // Fill the whole store with a long, mostly-star mask.
    set_mask_length(8'd255);
    for (p = 0; p < MDEPTH; p++) begin
      queue_req(REQ_LOAD, 8'(p), (p % 37 == 5) ? pick_letter() :
                                 (p % 53 == 7) ? CHAR_ANY : CHAR_STAR);
    end
    derive_subject(subj, 7);
    queue_subject(subj, 1'b1);
    derive_subject(subj, 7);
    mutate_subject(subj);
    queue_subject(subj, 1'b1);

    while (gen_count < ITEM_GOAL) begin
      len_pick = $urandom_range(0, 19);
      if (len_pick == 0) begin
        set_mask_length(8'd0);
      end else if (len_pick == 1) begin
        set_mask_length(8'd255);
      end else if (len_pick < 5) begin
        set_mask_length(8'($urandom_range(9, LONG_MASK)));
      end else begin
        set_mask_length(8'($urandom_range(1, 8)));
      end
      if (!hold_arm && gen_count > ITEM_GOAL / 2) begin
        hold_arm <= 1'b1;
      end
      if (plan_len <= LONG_MASK) begin
        for (p = 0; p < plan_len; p++) begin
          if ($urandom_range(0, 9) != 0) begin
            queue_req(REQ_LOAD, 8'(p), mask_char());
          end
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_req(REQ_LOAD, 8'($urandom_range(0, 255)), mask_char());
        end
      end
      nsub = (plan_len > LONG_MASK) ? 2 : $urandom_range(2, 5);
      stretch = (plan_len > LONG_MASK) ? 7 : 1;
      repeat (nsub) begin
        kind = $urandom_range(0, 19);
        if (kind < 11) begin
          derive_subject(subj, stretch);
        end else if (kind < 15) begin
          derive_subject(subj, stretch);
          mutate_subject(subj);
        end else if (kind < 18) begin
          subj = {};
          repeat ($urandom_range(0, 8)) subj.push_back(text_char());
        end else begin
          repeat ($urandom_range(1, 3)) begin
            queue_req(REQ_CHAR, 8'($urandom_range(0, 255)), text_char());
          end
          queue_req(REQ_LOAD, 8'($urandom_range(0, 255)), mask_char());
          derive_subject(subj, stretch);
        end
        queue_subject(subj, 1'b1);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d transactions, %0d results checked (%0d matches), %0d %s",
             items_accepted, results_checked, matches_seen, cfg_writes,
             "mask_length writes.");
    $display("Input stalled for %0d cycles, including one output hold of %0d cycles.",
             stall_cycles, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("glob_wildcard_matcher verification clean");
    end else begin
      $display("glob_wildcard_matcher verification failed");
    end
    $finish;
  end

endmodule
